// ----- design/tup_pkg.sv -----
// ----------------------------------------------------------------------------
// tup_pkg: shared definitions for the text to unsigned parser
// Character codes, the classified character word, parse phases and helpers.
// ----------------------------------------------------------------------------
package tup_pkg;

  // default widths, handed to the top level parameters
  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned INDEX_BITS_DEF = 16;

  // classified character queue depth
  localparam int unsigned QUEUE_DEPTH = 4;

  // radix and digit widths
  localparam int unsigned BASE_W = 6;
  localparam logic [BASE_W-1:0] DIGIT_NONE = 6'h3f;
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_BIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

  // register indexes
  localparam logic REG_NUMBER_BASE = 1'b0;

  // character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_B = 8'h42;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  // one classified character
  typedef struct packed {
    logic              nul;
    logic              space;
    logic              minus;
    logic              plus;
    logic              zero;
    logic              pfx_b;
    logic              pfx_x;
    logic [BASE_W-1:0] digit;
    logic              last;
  } token_t;

  // parse phases
  typedef enum logic [4:0] {
    PH_START      = 5'b00001,
    PH_SIGNED     = 5'b00010,
    PH_AFTER_ZERO = 5'b00100,
    PH_DIGITS     = 5'b01000,
    PH_DONE       = 5'b10000
  } phase_e;

  // digit value of a character, DIGIT_NONE when it is no digit
  function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'hff;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d = c - CH_LOWER_A + 8'd10;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d = c - CH_UPPER_A + 8'd10;
    end
    return (d == 8'hff) ? DIGIT_NONE : d[BASE_W-1:0];
  endfunction

  // limit a radix to 2..36
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    r = b;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end
    return r;
  endfunction

endpackage

// ----- design/tup_front.sv -----
// ----------------------------------------------------------------------------
// tup_front: character classifier
// Accepts characters from the input stream and turns each into a token word.
// ----------------------------------------------------------------------------
module tup_front (
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [7:0]      s_axis_tdata_i,
  input  logic            s_axis_tlast_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output tup_pkg::token_t q_token_o
);

  logic [7:0] c;

  assign c = s_axis_tdata_i;

  // accept whenever the queue has room
  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  // classify the character
  always_comb begin
    q_token_o.nul   = (c == tup_pkg::CH_NUL);
    q_token_o.space = (c == tup_pkg::CH_SPACE) ||
                      (c >= tup_pkg::CH_TAB && c <= tup_pkg::CH_CR);
    q_token_o.minus = (c == tup_pkg::CH_MINUS);
    q_token_o.plus  = (c == tup_pkg::CH_PLUS);
    q_token_o.zero  = (c == tup_pkg::CH_ZERO);
    q_token_o.pfx_b = (c == tup_pkg::CH_LOWER_B) || (c == tup_pkg::CH_UPPER_B);
    q_token_o.pfx_x = (c == tup_pkg::CH_LOWER_X) || (c == tup_pkg::CH_UPPER_X);
    q_token_o.digit = tup_pkg::digit_of(c);
    q_token_o.last  = s_axis_tlast_i;
  end

endmodule

// ----- design/tup_queue.sv -----
// ----------------------------------------------------------------------------
// tup_queue: token queue
// Short first-in first-out buffer between the classifier and the parser core.
// ----------------------------------------------------------------------------
module tup_queue #(
  parameter int unsigned DEPTH = tup_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tup_pkg::token_t token_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output tup_pkg::token_t token_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tup_pkg::token_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign token_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= token_i;
    end
  end

endmodule

// ----- design/tup_back.sv -----
// ----------------------------------------------------------------------------
// tup_back: parser core
// Parses one token a cycle unless a result stalls; holds the result word.
// ----------------------------------------------------------------------------
module tup_back #(
  parameter int unsigned VALUE_BITS = tup_pkg::VALUE_BITS_DEF,
  parameter int unsigned INDEX_BITS = tup_pkg::INDEX_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tup_pkg::BASE_W-1:0] number_base_i,
  input  logic                       tok_valid_i,
  input  tup_pkg::token_t            tok_i,
  output logic                       tok_pop_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [VALUE_BITS-1:0]      res_value_o,
  output logic                       res_overflowed_o,
  output logic [INDEX_BITS-1:0]      res_end_offset_o
);

  localparam int unsigned BW    = tup_pkg::BASE_W;
  localparam int unsigned SUM_W = VALUE_BITS + BW;

  // string state
  tup_pkg::phase_e        phase_q, phase_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic                   neg_q, neg_d;
  logic [BW-1:0]          base_q, base_d;
  logic [INDEX_BITS-1:0]  idx_q, idx_d;
  logic                   ov_q, ov_d;

  // result register
  logic                   out_valid_q;
  logic [VALUE_BITS-1:0]  out_acc_q;
  logic                   out_neg_q;
  logic                   out_ov_q;
  logic [INDEX_BITS-1:0]  out_off_q;

  logic [BW-1:0]          start_base, zero_base, b_cur;
  logic [VALUE_BITS-1:0]  mul_acc;
  logic [SUM_W-1:0]       sum;
  logic                   fits;
  logic                   emit;
  logic [VALUE_BITS-1:0]  e_acc;
  logic                   e_neg, e_ov;
  logic [INDEX_BITS-1:0]  e_off;
  logic                   out_free;
  logic                   nb_auto;

  assign nb_auto    = (number_base_i == tup_pkg::BASE_AUTO);
  assign start_base = tup_pkg::clamp_base(nb_auto ? tup_pkg::BASE_DEC : number_base_i);
  assign zero_base  = tup_pkg::clamp_base(nb_auto ? tup_pkg::BASE_OCT : number_base_i);

  // radix and accumulator feeding the digit step
  always_comb begin
    if (phase_q == tup_pkg::PH_DIGITS) begin
      b_cur   = base_q;
      mul_acc = acc_q;
    end else if (phase_q == tup_pkg::PH_AFTER_ZERO) begin
      b_cur   = zero_base;
      mul_acc = '0;
    end else begin
      b_cur   = start_base;
      mul_acc = '0;
    end
  end

  // multiply-add and range check
  assign sum  = SUM_W'(mul_acc) * SUM_W'(b_cur) + SUM_W'(tok_i.digit);
  assign fits = (sum[SUM_W-1:VALUE_BITS] == '0);

  // parse step, then the implied terminator of a last character
  always_comb begin
    logic do_digit;
    do_digit = 1'b0;
    phase_d  = phase_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    base_d   = base_q;
    ov_d     = ov_q;
    idx_d    = idx_q;
    emit     = 1'b0;
    e_acc    = mul_acc;
    e_neg    = neg_q;
    e_ov     = ov_q;
    e_off    = idx_q;

    unique case (phase_q)
      tup_pkg::PH_START: begin
        if (tok_i.space) begin
          phase_d = tup_pkg::PH_START;
        end else if (tok_i.minus) begin
          neg_d   = 1'b1;
          phase_d = tup_pkg::PH_SIGNED;
        end else if (tok_i.plus) begin
          phase_d = tup_pkg::PH_SIGNED;
        end else if (tok_i.zero) begin
          phase_d = tup_pkg::PH_AFTER_ZERO;
        end else begin
          do_digit = 1'b1;
        end
      end
      tup_pkg::PH_SIGNED: begin
        if (tok_i.zero) begin
          phase_d = tup_pkg::PH_AFTER_ZERO;
        end else begin
          do_digit = 1'b1;
        end
      end
      tup_pkg::PH_AFTER_ZERO: begin
        if ((nb_auto || number_base_i == tup_pkg::BASE_BIN) && tok_i.pfx_b) begin
          base_d  = tup_pkg::BASE_BIN;
          phase_d = tup_pkg::PH_DIGITS;
        end else if ((nb_auto || number_base_i == tup_pkg::BASE_HEX) && tok_i.pfx_x) begin
          base_d  = tup_pkg::BASE_HEX;
          phase_d = tup_pkg::PH_DIGITS;
        end else begin
          do_digit = 1'b1;
        end
      end
      tup_pkg::PH_DIGITS: begin
        do_digit = 1'b1;
      end
      tup_pkg::PH_DONE: begin
        phase_d = tup_pkg::PH_DONE;
      end
      default: begin
        phase_d = tup_pkg::PH_DONE;
      end
    endcase

    // digit or end of the number
    if (do_digit) begin
      base_d  = b_cur;
      phase_d = tup_pkg::PH_DIGITS;
      if (tok_i.digit < b_cur) begin
        if (!ov_q && fits) begin
          acc_d = sum[VALUE_BITS-1:0];
        end else begin
          ov_d = 1'b1;
        end
      end else begin
        emit    = 1'b1;
        phase_d = tup_pkg::PH_DONE;
      end
    end

    // a last character acts as if a terminator followed it
    if (tok_i.last && !tok_i.nul && !emit && phase_d != tup_pkg::PH_DONE) begin
      emit  = 1'b1;
      e_acc = acc_d;
      e_neg = neg_d;
      e_ov  = ov_d;
      e_off = idx_q + 1'b1;
    end

    // end of string re-arms, otherwise advance the index
    if (tok_i.nul || tok_i.last) begin
      phase_d = tup_pkg::PH_START;
      acc_d   = '0;
      neg_d   = 1'b0;
      base_d  = '0;
      ov_d    = 1'b0;
      idx_d   = '0;
    end else begin
      idx_d = idx_q + 1'b1;
    end
  end

  // take a token unless its result has nowhere to go
  assign out_free  = !out_valid_q || res_ready_i;
  assign tok_pop_o = tok_valid_i && (!emit || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tup_pkg::PH_START;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      base_q  <= '0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else if (tok_pop_o) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      base_q  <= base_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  // result word valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tok_pop_o && emit) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk_i) begin
    if (tok_pop_o && emit) begin
      out_acc_q <= e_acc;
      out_neg_q <= e_neg;
      out_ov_q  <= e_ov;
      out_off_q <= e_off;
    end
  end

  // final value: all ones on overflow, else two's complement (negated on minus)
  assign res_valid_o      = out_valid_q;
  assign res_value_o      = out_ov_q  ? '1 :
                            out_neg_q ? (VALUE_BITS'(0) - out_acc_q) : out_acc_q;
  assign res_overflowed_o = out_ov_q;
  assign res_end_offset_o = out_off_q;

endmodule

// ----- design/text_to_unsigned_parser.sv -----
// ----------------------------------------------------------------------------
// text_to_unsigned_parser: streaming text to unsigned integer converter
// Parses one character per word in the manner of strtoul, one result a string.
// ----------------------------------------------------------------------------
// The block takes one character a cycle and gives one result word per string.
// The result word is registered: the character that ends the number (first
// non-digit, a zero byte, or the character marked last) passes the token
// queue, and the result register is set when the parser core takes it.
// The rate of one character per cycle is set by the parser core, which folds
// each digit into the accumulator with a single multiply-add and range check
// per cycle; a four-word token queue sits between the classifier and the core,
// so a stalled result only holds up input once that queue is full. Write the
// radix register only while the block is idle. There is no clearing pass
// after reset.
module text_to_unsigned_parser #(
  parameter int unsigned VALUE_BITS = tup_pkg::VALUE_BITS_DEF,
  parameter int unsigned INDEX_BITS = tup_pkg::INDEX_BITS_DEF,
  localparam int unsigned OUT_W     = ((VALUE_BITS + 1 + INDEX_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input stream
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // char_code
  input  logic             s_axis_tlast_i,   // last_char
  // result stream
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o,   // value, overflowed, end_offset
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned BW = tup_pkg::BASE_W;

  logic [BW-1:0]         number_base_q;
  logic                  q_full, q_push, q_valid, q_pop;
  tup_pkg::token_t       tok_in, tok_out;
  logic [VALUE_BITS-1:0] res_value;
  logic                  res_overflowed;
  logic [INDEX_BITS-1:0] res_end_offset;

  // radix register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= tup_pkg::BASE_AUTO;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == tup_pkg::REG_NUMBER_BASE) begin
      number_base_q <= pwdata[BW-1:0];
    end
  end

  assign prdata = (paddr[2] == tup_pkg::REG_NUMBER_BASE) ? 32'(number_base_q) : '0;

  tup_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_token_o       (tok_in)
  );

  tup_queue #(
    .DEPTH (tup_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .token_i (tok_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .token_o (tok_out)
  );

  tup_back #(
    .VALUE_BITS (VALUE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .number_base_i    (number_base_q),
    .tok_valid_i      (q_valid),
    .tok_i            (tok_out),
    .tok_pop_o        (q_pop),
    .res_valid_o      (m_axis_tvalid_o),
    .res_ready_i      (m_axis_tready_i),
    .res_value_o      (res_value),
    .res_overflowed_o (res_overflowed),
    .res_end_offset_o (res_end_offset)
  );

  // pack the result word, zero filled to whole bytes
  assign m_axis_tdata_o = OUT_W'({res_end_offset, res_overflowed, res_value});

endmodule

// ----- design/tup_checker.sv -----
// ----------------------------------------------------------------------------
// tup_checker: port level checks for the text to unsigned parser
// Watches the top level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module tup_checker #(
  parameter int unsigned VALUE_BITS = tup_pkg::VALUE_BITS_DEF,
  parameter int unsigned INDEX_BITS = tup_pkg::INDEX_BITS_DEF,
  localparam int unsigned OUT_W     = ((VALUE_BITS + 1 + INDEX_BITS + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o,
  input logic             psel,
  input logic             penable,
  input logic             pwrite,
  input logic [2:0]       paddr,
  input logic [31:0]      pwdata,
  input logic [31:0]      prdata,
  input logic             pready
);

  localparam int unsigned BW = tup_pkg::BASE_W;

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // overflow forces an all ones value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[VALUE_BITS] |->
      m_axis_tdata_o[VALUE_BITS-1:0] == {VALUE_BITS{1'b1}})
    else $error("overflow without saturated value");

  // radix write reads back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[2] == tup_pkg::REG_NUMBER_BASE |=>
      (paddr[2] != tup_pkg::REG_NUMBER_BASE) || (prdata[BW-1:0] == $past(pwdata[BW-1:0])))
    else $error("radix register read back mismatch");

  // configuration port never waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("configuration access stalled");

endmodule

bind text_to_unsigned_parser tup_checker #(
  .VALUE_BITS (VALUE_BITS),
  .INDEX_BITS (INDEX_BITS)
) u_tup_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata),
  .pready          (pready)
);
